>>> rtl/assert_macros.svh
// Assertion macros shared by the quaternion rotator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property with reset disable; the label names the check.
`define QAAR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// A condition that must never be seen at a clock edge.
`define QAAR_ASSERT_NEVER(lbl, cond, msg) \
  `QAAR_ASSERT(lbl, !(cond), msg)

`endif

>>> rtl/qaar_pkg.sv
// Types, constants and tables of the quaternion axis-angle rotator.
package qaar_pkg;

  localparam int QW = 18;
  localparam int ANGW = 20;

  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_ROTATE = 1'b1;

  // Constants in Q.30: the CORDIC gain C_K and angles in radians.
  localparam logic signed [34:0] C_K       = 35'sd652032874;
  localparam logic signed [34:0] C_PI      = 35'sd3373259426;
  localparam logic signed [34:0] C_HALF_PI = 35'sd1686629713;
  localparam logic signed [34:0] C_TWO_PI  = 35'sd6746518852;

  typedef enum logic [3:0] {
    ST_IDLE, ST_TRIG, ST_RVEC, ST_HAM1, ST_HAM2, ST_SCALE,
    ST_SQ, ST_SQRT, ST_DIV_GO, ST_DIV_WAIT, ST_OUT
  } qaar_state_e;

  typedef enum logic [2:0] {
    SC_IDLE, SC_REDUCE, SC_FOLD, SC_ROTATE, SC_DONE
  } qaar_sc_state_e;

  typedef struct packed {
    logic en;
    logic first;
    logic neg;
  } qaar_mac_ctl_t;

  typedef struct packed {
    logic [1:0] ia;
    logic [1:0] ib;
    logic       neg;
  } ham_term_t;

  // Term order of the Hamilton product: index = component * 4 + term.
  function automatic ham_term_t ham_term(input logic [3:0] idx);
    ham_term_t t;
    case (idx)
      4'd0:    t = '{2'd0, 2'd0, 1'b0};
      4'd1:    t = '{2'd1, 2'd1, 1'b1};
      4'd2:    t = '{2'd2, 2'd2, 1'b1};
      4'd3:    t = '{2'd3, 2'd3, 1'b1};
      4'd4:    t = '{2'd0, 2'd1, 1'b0};
      4'd5:    t = '{2'd1, 2'd0, 1'b0};
      4'd6:    t = '{2'd2, 2'd3, 1'b0};
      4'd7:    t = '{2'd3, 2'd2, 1'b1};
      4'd8:    t = '{2'd0, 2'd2, 1'b0};
      4'd9:    t = '{2'd1, 2'd3, 1'b1};
      4'd10:   t = '{2'd2, 2'd0, 1'b0};
      4'd11:   t = '{2'd3, 2'd1, 1'b0};
      4'd12:   t = '{2'd0, 2'd3, 1'b0};
      4'd13:   t = '{2'd1, 2'd2, 1'b0};
      4'd14:   t = '{2'd2, 2'd1, 1'b1};
      4'd15:   t = '{2'd3, 2'd0, 1'b0};
      default: t = '{2'd0, 2'd0, 1'b0};
    endcase
    return t;
  endfunction

  // atan(2^-i) in Q.30.
  function automatic logic [29:0] atan_q30(input logic [4:0] i);
    logic [29:0] v;
    case (i)
      5'd0:    v = 30'd843314857;
      5'd1:    v = 30'd497837829;
      5'd2:    v = 30'd263043837;
      5'd3:    v = 30'd133525159;
      5'd4:    v = 30'd67021687;
      5'd5:    v = 30'd33543516;
      5'd6:    v = 30'd16775851;
      5'd7:    v = 30'd8388437;
      5'd8:    v = 30'd4194283;
      5'd9:    v = 30'd2097149;
      5'd10:   v = 30'd1048576;
      5'd11:   v = 30'd524288;
      5'd12:   v = 30'd262144;
      5'd13:   v = 30'd131072;
      5'd14:   v = 30'd65536;
      5'd15:   v = 30'd32768;
      5'd16:   v = 30'd16384;
      5'd17:   v = 30'd8192;
      5'd18:   v = 30'd4096;
      5'd19:   v = 30'd2048;
      5'd20:   v = 30'd1024;
      5'd21:   v = 30'd512;
      5'd22:   v = 30'd256;
      5'd23:   v = 30'd128;
      5'd24:   v = 30'd64;
      5'd25:   v = 30'd32;
      5'd26:   v = 30'd16;
      5'd27:   v = 30'd8;
      5'd28:   v = 30'd4;
      5'd29:   v = 30'd2;
      5'd30:   v = 30'd1;
      default: v = 30'd0;
    endcase
    return v;
  endfunction

endpackage

>>> rtl/qaar_mac.sv
// Shared signed multiply-accumulate unit with one accumulator register.
module qaar_mac #(
  parameter int MA = 32,
  parameter int MB = 32,
  parameter int AW = 66
) (
  input  logic                  clk_i,
  input  qaar_pkg::qaar_mac_ctl_t ctl_i,
  input  logic signed [MA-1:0]  a_i,
  input  logic signed [MB-1:0]  b_i,
  output logic signed [AW-1:0]  sum_o
);
  import qaar_pkg::*;

  logic signed [MA+MB-1:0] prod;
  logic signed [AW-1:0]    ext;
  logic signed [AW-1:0]    base;
  logic signed [AW-1:0]    acc_q;

  assign prod  = a_i * b_i;
  assign ext   = AW'(prod);
  assign base  = ctl_i.first ? '0 : acc_q;
  assign sum_o = ctl_i.neg ? (base - ext) : (base + ext);

  always_ff @(posedge clk_i) begin
    if (ctl_i.en) begin
      acc_q <= sum_o;
    end
  end

endmodule

>>> rtl/qaar_sincos.sv
// Half-angle range reduction and rotation-mode CORDIC for cos and sin.
module qaar_sincos #(
  parameter int FRAC_BITS = 16,
  parameter int CORDIC_ITERATIONS = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic signed [19:0]       angle_i,
  output logic                     done_o,
  output logic signed [FRAC_BITS+2:0] cos_o,
  output logic signed [FRAC_BITS+2:0] sin_o
);
  import qaar_pkg::*;

  localparam int SH = 30 - FRAC_BITS;
  localparam int TW = (50 - FRAC_BITS > 35) ? 50 - FRAC_BITS : 35;
  localparam int RK = (FRAC_BITS < 16) ? 16 - FRAC_BITS : 0;
  localparam int KW = (RK > 0) ? $clog2(RK + 1) : 1;
  localparam int IW = $clog2(CORDIC_ITERATIONS);
  localparam int CW = FRAC_BITS + 3;
  localparam logic signed [34:0] RHALF = 35'((2 ** SH) / 2);

  qaar_sc_state_e state_q, state_d;
  logic [TW-1:0]      mag_q;
  logic               sign_q;
  logic [KW-1:0]      k_q;
  logic [IW-1:0]      i_q;
  logic signed [34:0] t_q, x_q, y_q;
  logic               neg_q;
  logic               done_q;
  logic signed [CW-1:0] cos_q, sin_q;

  logic signed [TW:0]   ang_ext, ang_sh, t0;
  logic [TW-1:0]        two_pi_k;
  logic signed [34:0]   tr, tf, tg, ys, xs, xn, yn, at;
  logic                 negf;

  assign ang_ext  = (TW+1)'(angle_i);
  assign ang_sh   = ang_ext <<< SH;
  assign t0       = ang_sh >>> 1;
  assign two_pi_k = TW'(C_TWO_PI) << k_q;

  always_comb begin
    tr = sign_q ? -35'(mag_q) : 35'(mag_q);
    tf = tr;
    if (tr > C_PI) begin
      tf = tr - C_TWO_PI;
    end else if (tr < -C_PI) begin
      tf = tr + C_TWO_PI;
    end
    tg   = tf;
    negf = 1'b0;
    if (tf > C_HALF_PI) begin
      tg   = tf - C_PI;
      negf = 1'b1;
    end else if (tf < -C_HALF_PI) begin
      tg   = tf + C_PI;
      negf = 1'b1;
    end
  end

  assign ys = y_q >>> i_q;
  assign xs = x_q >>> i_q;
  assign at = 35'(atan_q30(5'(i_q)));
  assign xn = neg_q ? -x_q : x_q;
  assign yn = neg_q ? -y_q : y_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      SC_IDLE:   if (start_i) state_d = SC_REDUCE;
      SC_REDUCE: if (k_q == '0) state_d = SC_FOLD;
      SC_FOLD:   state_d = SC_ROTATE;
      SC_ROTATE: if (i_q == IW'(CORDIC_ITERATIONS - 1)) state_d = SC_DONE;
      SC_DONE:   state_d = SC_IDLE;
      default:   state_d = SC_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SC_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == SC_DONE);
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      SC_IDLE: begin
        if (start_i) begin
          sign_q <= t0[TW];
          mag_q  <= TW'(t0[TW] ? -t0 : t0);
          k_q    <= KW'(RK);
        end
      end
      SC_REDUCE: begin
        if (mag_q >= two_pi_k) begin
          mag_q <= mag_q - two_pi_k;
        end
        k_q <= k_q - 1'b1;
      end
      SC_FOLD: begin
        t_q   <= tg;
        neg_q <= negf;
        x_q   <= C_K;
        y_q   <= '0;
        i_q   <= '0;
      end
      SC_ROTATE: begin
        if (!t_q[34]) begin
          x_q <= x_q - ys;
          y_q <= y_q + xs;
          t_q <= t_q - at;
        end else begin
          x_q <= x_q + ys;
          y_q <= y_q - xs;
          t_q <= t_q + at;
        end
        i_q <= i_q + 1'b1;
      end
      SC_DONE: begin
        cos_q <= CW'((xn + RHALF) >>> SH);
        sin_q <= CW'((yn + RHALF) >>> SH);
      end
      default: ;
    endcase
  end

  assign done_o = done_q;
  assign cos_o  = cos_q;
  assign sin_o  = sin_q;

endmodule

>>> rtl/qaar_sqrt.sv
// Digit-by-digit integer square root of a 64-bit value, one digit a cycle.
module qaar_sqrt (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] n_i,
  output logic        done_o,
  output logic [31:0] root_o
);
  import qaar_pkg::*;

  logic        busy_q, done_q;
  logic [4:0]  i_q;
  logic [63:0] n_q, res_q, bit_v, trial;

  assign bit_v = 64'd1 << (7'd62 - 7'({i_q, 1'b0}));
  assign trial = res_q + bit_v;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= busy_q && (i_q == 5'd31);
      if (start_i) begin
        busy_q <= 1'b1;
      end else if (i_q == 5'd31) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      n_q   <= n_i;
      res_q <= '0;
      i_q   <= '0;
    end else if (busy_q) begin
      if (n_q >= trial) begin
        n_q   <= n_q - trial;
        res_q <= (res_q >> 1) + bit_v;
      end else begin
        res_q <= res_q >> 1;
      end
      i_q <= i_q + 1'b1;
    end
  end

  assign done_o = done_q;
  assign root_o = res_q[31:0];

endmodule

>>> rtl/qaar_div.sv
// Restoring divider for the rounded normalisation quotient, one bit a cycle.
module qaar_div #(
  parameter int FRAC_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [30:0] num_i,
  input  logic [31:0] den_i,
  output logic        done_o,
  output logic [18:0] quo_o,
  output logic        ovf_o
);
  import qaar_pkg::*;

  localparam int DW = (FRAC_BITS + 33 > 52) ? FRAC_BITS + 33 : 52;

  logic          busy_q, done_q, ovf_q;
  logic [4:0]    i_q;
  logic [DW-1:0] rem_q, num_v, sub_v;
  logic [31:0]   den_q;
  logic [18:0]   quo_q;

  // Numerator carries half the divisor so that the quotient rounds to nearest.
  assign num_v = (DW'(num_i) << FRAC_BITS) + DW'(den_i >> 1);
  assign sub_v = DW'(den_q) << i_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= busy_q && (i_q == 5'd0);
      if (start_i) begin
        busy_q <= 1'b1;
      end else if (i_q == 5'd0) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= num_v;
      den_q <= den_i;
      ovf_q <= num_v >= (DW'(den_i) << 19);
      quo_q <= '0;
      i_q   <= 5'd18;
    end else if (busy_q) begin
      if (rem_q >= sub_v) begin
        rem_q      <= rem_q - sub_v;
        quo_q[i_q] <= 1'b1;
      end
      i_q <= i_q - 1'b1;
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;
  assign ovf_o  = ovf_q;

endmodule

>>> rtl/quaternion_axis_angle_rotate_unit.sv
// Top level of the quaternion axis-angle rotator: sequencer and operand store.
//
//  Channel | Direction | Handshake               | Beat contents
//  --------+-----------+-------------------------+------------------------------------
//  in      | input     | in_valid_i / in_ready_o | op, load_w..z, axis_x..z, angle
//  out     | output    | out_valid_o / out_ready_i | out_w..z, zero_magnitude
//
// A load beat writes the orientation and moves to the output state, which copies it into
// the output register once that register is free. A rotate beat computes the half angle
// sine and cosine, runs 39 products on the shared multiply-accumulate unit, halves u
// until it fits the squaring operand, takes the square root, performs four 19 bit
// divisions unless the magnitude is zero and then loads the output. The input reopens
// the cycle after the output register is loaded.
// After reset the orientation is zero and the block is ready at once.
// A stalled output holds the finished result and keeps the input side closed.
`include "assert_macros.svh"

module quaternion_axis_angle_rotate_unit #(
  parameter int FRAC_BITS = 16,
  parameter int CORDIC_ITERATIONS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               op_i,
  input  logic signed [17:0] load_w_i,
  input  logic signed [17:0] load_x_i,
  input  logic signed [17:0] load_y_i,
  input  logic signed [17:0] load_z_i,
  input  logic signed [17:0] axis_x_i,
  input  logic signed [17:0] axis_y_i,
  input  logic signed [17:0] axis_z_i,
  input  logic signed [19:0] angle_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [17:0] out_w_o,
  output logic signed [17:0] out_x_o,
  output logic signed [17:0] out_y_o,
  output logic signed [17:0] out_z_o,
  output logic               zero_magnitude_o
);
  import qaar_pkg::*;

  // Widths of the rotor, of the first product and of the rotated quaternion.
  localparam int RW = (FRAC_BITS + 2 > 19) ? FRAC_BITS + 2 : 19;
  localparam int PW = ((36 - FRAC_BITS > 19) ? 36 - FRAC_BITS : 19) + 3;
  localparam int UW = PW + RW + 2 - FRAC_BITS;
  localparam int MA = (PW > 32) ? PW : 32;
  localparam int MB = (RW > 32) ? RW : 32;
  localparam int AW = MA + MB + 2;
  localparam int CW = FRAC_BITS + 3;
  localparam logic signed [AW-1:0] RND_HALF = AW'(2 ** (FRAC_BITS - 1));
  localparam logic signed [63:0] LIM_HI = 64'sd2147483648;
  localparam logic signed [63:0] LIM_LO = -64'sd2147483648;

  qaar_state_e state_q, state_d;
  logic [3:0]  cnt_q;

  logic signed [17:0]   orient_q [4];
  logic signed [17:0]   ax_q [3];
  logic signed [CW-1:0] s_q;
  logic signed [RW-1:0] r_q [4];
  logic signed [PW-1:0] p_q [4];
  logic signed [UW-1:0] u_q [4];
  logic [31:0]          mag_q;
  logic                 zflag_q;

  logic               out_valid_q, out_zero_q;
  logic signed [17:0] out_q [4];

  logic in_acc, out_load;

  // Shared multiply-accumulate unit and its operands.
  qaar_mac_ctl_t        mac_ctl;
  logic signed [MA-1:0] mac_a;
  logic signed [MB-1:0] mac_b;
  logic signed [AW-1:0] mac_sum;
  logic signed [AW-1:0] rnd_v;
  ham_term_t            term;
  logic signed [31:0]   u32;
  logic [30:0]          u_abs;
  logic                 big_any;

  logic                 sc_start, sc_done;
  logic signed [CW-1:0] sc_cos, sc_sin;
  logic                 sqrt_start, sqrt_done;
  logic [31:0]          sqrt_root;
  logic                 div_start, div_done, div_ovf;
  logic [18:0]          div_quo;
  logic [18:0]          quo_sat, res19;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign out_load   = (state_q == ST_OUT) && (!out_valid_q || out_ready_i);

  assign term  = ham_term(cnt_q);
  assign rnd_v = (mac_sum + RND_HALF) >>> FRAC_BITS;
  assign u32   = 32'(u_q[cnt_q[1:0]]);
  assign u_abs = 31'(u32[31] ? -u32 : u32);

  always_comb begin
    big_any = 1'b0;
    for (int k = 0; k < 4; k++) begin
      if ((64'(u_q[k]) >= LIM_HI) || (64'(u_q[k]) <= LIM_LO)) begin
        big_any = 1'b1;
      end
    end
  end

  // Rounded quotient, clamped to the 18 bit signed range with the sign of u.
  always_comb begin
    quo_sat = (div_ovf || (div_quo > 19'd131072)) ? 19'd131072 : div_quo;
    if (u32[31]) begin
      res19 = 19'(19'd0 - quo_sat);
    end else begin
      res19 = (quo_sat > 19'd131071) ? 19'd131071 : quo_sat;
    end
  end

  always_comb begin
    mac_ctl = '{en: 1'b0, first: 1'b0, neg: 1'b0};
    mac_a   = '0;
    mac_b   = '0;
    case (state_q)
      ST_RVEC: begin
        mac_ctl = '{en: 1'b1, first: 1'b1, neg: 1'b0};
        mac_a   = MA'(ax_q[cnt_q[1:0]]);
        mac_b   = MB'(s_q);
      end
      ST_HAM1: begin
        mac_ctl = '{en: 1'b1, first: (cnt_q[1:0] == 2'd0), neg: term.neg};
        mac_a   = MA'(r_q[term.ia]);
        mac_b   = MB'(orient_q[term.ib]);
      end
      ST_HAM2: begin
        // The conjugate rotor flips the sign of every vector term.
        mac_ctl = '{en: 1'b1, first: (cnt_q[1:0] == 2'd0),
                    neg: term.neg ^ (term.ib != 2'd0)};
        mac_a   = MA'(p_q[term.ia]);
        mac_b   = MB'(r_q[term.ib]);
      end
      ST_SQ: begin
        mac_ctl = '{en: 1'b1, first: (cnt_q[1:0] == 2'd0), neg: 1'b0};
        mac_a   = MA'(u32);
        mac_b   = MB'(u32);
      end
      default: ;
    endcase
  end

  assign sc_start   = in_acc && (op_i == OP_ROTATE);
  assign sqrt_start = (state_q == ST_SQ) && (cnt_q[1:0] == 2'd3);
  assign div_start  = (state_q == ST_DIV_GO);

  qaar_mac #(.MA(MA), .MB(MB), .AW(AW)) u_mac (
    .clk_i (clk_i),
    .ctl_i (mac_ctl),
    .a_i   (mac_a),
    .b_i   (mac_b),
    .sum_o (mac_sum)
  );

  qaar_sincos #(
    .FRAC_BITS        (FRAC_BITS),
    .CORDIC_ITERATIONS(CORDIC_ITERATIONS)
  ) u_sincos (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(sc_start),
    .angle_i(angle_i),
    .done_o (sc_done),
    .cos_o  (sc_cos),
    .sin_o  (sc_sin)
  );

  qaar_sqrt u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(sqrt_start),
    .n_i    (mac_sum[63:0]),
    .done_o (sqrt_done),
    .root_o (sqrt_root)
  );

  qaar_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (u_abs),
    .den_i  (mag_q),
    .done_o (div_done),
    .quo_o  (div_quo),
    .ovf_o  (div_ovf)
  );

  // Sequencer: next state only; the datapath below follows the same states.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          state_d = (op_i == OP_LOAD) ? ST_OUT : ST_TRIG;
        end
      end
      ST_TRIG:     if (sc_done) state_d = ST_RVEC;
      ST_RVEC:     if (cnt_q == 4'd2) state_d = ST_HAM1;
      ST_HAM1:     if (cnt_q == 4'd15) state_d = ST_HAM2;
      ST_HAM2:     if (cnt_q == 4'd15) state_d = ST_SCALE;
      ST_SCALE:    if (!big_any) state_d = ST_SQ;
      ST_SQ:       if (cnt_q[1:0] == 2'd3) state_d = ST_SQRT;
      ST_SQRT: begin
        if (sqrt_done) begin
          state_d = (sqrt_root == 32'd0) ? ST_OUT : ST_DIV_GO;
        end
      end
      ST_DIV_GO:   state_d = ST_DIV_WAIT;
      ST_DIV_WAIT: begin
        if (div_done) begin
          state_d = (cnt_q[1:0] == 2'd3) ? ST_OUT : ST_DIV_GO;
        end
      end
      ST_OUT:      if (out_load) state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      for (int k = 0; k < 4; k++) begin
        orient_q[k] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (in_acc && (op_i == OP_LOAD)) begin
        orient_q[0] <= load_w_i;
        orient_q[1] <= load_x_i;
        orient_q[2] <= load_y_i;
        orient_q[3] <= load_z_i;
      end else if ((state_q == ST_SQRT) && sqrt_done && (sqrt_root == 32'd0)) begin
        // A zero magnitude means every component of u is zero already.
        for (int k = 0; k < 4; k++) begin
          orient_q[k] <= '0;
        end
      end else if ((state_q == ST_DIV_WAIT) && div_done) begin
        orient_q[cnt_q[1:0]] <= res19[17:0];
      end
    end
  end

  // Datapath registers: operands, partial results and the step counter.
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          ax_q[0] <= axis_x_i;
          ax_q[1] <= axis_y_i;
          ax_q[2] <= axis_z_i;
          zflag_q <= 1'b0;
        end
      end
      ST_TRIG: begin
        if (sc_done) begin
          r_q[0] <= RW'(sc_cos);
          s_q    <= sc_sin;
          cnt_q  <= '0;
        end
      end
      ST_RVEC: begin
        r_q[2'(cnt_q[1:0] + 2'd1)] <= RW'(rnd_v);
        cnt_q <= (cnt_q == 4'd2) ? 4'd0 : cnt_q + 4'd1;
      end
      ST_HAM1: begin
        if (cnt_q[1:0] == 2'd3) begin
          p_q[cnt_q[3:2]] <= PW'(rnd_v);
        end
        cnt_q <= cnt_q + 4'd1;
      end
      ST_HAM2: begin
        if (cnt_q[1:0] == 2'd3) begin
          u_q[cnt_q[3:2]] <= UW'(rnd_v);
        end
        cnt_q <= cnt_q + 4'd1;
      end
      ST_SCALE: begin
        // Halve all four together until each fits the squaring operand.
        if (big_any) begin
          for (int k = 0; k < 4; k++) begin
            u_q[k] <= u_q[k] >>> 1;
          end
        end
        cnt_q <= '0;
      end
      ST_SQ: begin
        cnt_q <= (cnt_q[1:0] == 2'd3) ? 4'd0 : cnt_q + 4'd1;
      end
      ST_SQRT: begin
        if (sqrt_done) begin
          mag_q   <= sqrt_root;
          zflag_q <= (sqrt_root == 32'd0);
          cnt_q   <= '0;
        end
      end
      ST_DIV_WAIT: begin
        if (div_done) begin
          cnt_q <= cnt_q + 4'd1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      for (int k = 0; k < 4; k++) begin
        out_q[k] <= orient_q[k];
      end
      out_zero_q <= zflag_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign out_w_o          = out_q[0];
  assign out_x_o          = out_q[1];
  assign out_y_o          = out_q[2];
  assign out_z_o          = out_q[3];
  assign zero_magnitude_o = out_zero_q;

  // A load beat goes straight to the output stage.
  `QAAR_ASSERT(a_load_to_out, (in_acc && (op_i == OP_LOAD)) |=> (state_q == ST_OUT), "load beat did not reach the output stage")
  // The divider only ever runs against a non-zero magnitude.
  `QAAR_ASSERT_NEVER(a_div_zero, div_start && (mag_q == 32'd0), "division started with zero magnitude")
  // A zero-magnitude result carries an all-zero quaternion.
  `QAAR_ASSERT(a_zero_out, (out_valid_o && zero_magnitude_o) |-> ((out_w_o == 18'sd0) && (out_x_o == 18'sd0) && (out_y_o == 18'sd0) && (out_z_o == 18'sd0)), "zero magnitude with non-zero result")

endmodule
